>>> hw/rtl/vots_pkg.sv
// Package with shared types and constants for the voxel occupancy sampler.
`default_nettype none
package vots_pkg;
    localparam int FRAC_W = 16;
    localparam int PT_W = 32;
    localparam int MAX_DIM = 64;
    localparam logic [0:0] OP_WRITE = 1'b0;
    localparam logic [0:0] OP_QUERY = 1'b1;
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_SCALE_X = 3'd3;
    localparam logic [2:0] REG_SCALE_Y = 3'd4;
    localparam logic [2:0] REG_SCALE_Z = 3'd5;
    localparam logic [2:0] REG_GRID_DIMS = 3'd6;

    // Per-axis result of the coordinate mapping.
    typedef struct packed {
        logic              outside;
        logic              neg;
        logic [FRAC_W-1:0] frac;
        logic [16:0]       idx;
    } t_axis;
endpackage
`default_nettype wire

>>> hw/rtl/vots_axis.sv
// One axis of the coordinate mapping: subtract, multiply, range check, split.
`default_nettype none
module vots_axis (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [31:0]           i_point,
    input  wire logic [31:0]           i_origin,
    input  wire logic [31:0]           i_scale,
    input  wire logic [7:0]            i_dim,
    output vots_pkg::t_axis            o_axis
);
    import vots_pkg::*;

    logic signed [32:0] n_diff;
    logic        [32:0] r_diff;
    logic               r_zero_scale;
    logic        [31:0] r_scale;
    logic        [7:0]  r_dim1;
    logic        [63:0] r_prod;
    logic               r_neg2;
    logic               r_zs2;
    logic        [7:0]  r_dim2;
    logic        [47:0] w_v;
    logic        [47:0] w_lim;
    logic        [47:0] w_vm;
    t_axis              n_axis;

    assign n_diff = $signed({i_point[31], i_point}) - $signed({i_origin[31], i_origin});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff       <= n_diff;
            r_zero_scale <= (i_scale == 32'd0);
            r_scale      <= i_scale;
            r_dim1       <= i_dim;
            r_prod       <= {32'd0, r_diff[31:0]} * {32'd0, r_scale};
            r_neg2       <= r_diff[32];
            r_zs2        <= r_zero_scale;
            r_dim2       <= r_dim1;
            o_axis       <= n_axis;
        end
    end

    // A negative difference with zero scale maps to coordinate zero.
    assign w_v   = r_neg2 ? 48'd0 : r_prod[63:16];
    assign w_lim = {24'd0, r_dim2, 16'd0};
    assign w_vm  = w_v - 48'd32768;

    always_comb begin
        n_axis.outside = (r_neg2 && !r_zs2) || (w_v > w_lim);
        n_axis.neg     = (w_v < 48'd32768);
        n_axis.frac    = n_axis.neg ? w_v[15:0] + 16'd32768 : w_vm[15:0];
        n_axis.idx     = w_vm[32:16];
    end
endmodule
`default_nettype wire

>>> hw/rtl/vots_blend.sv
// Trilinear blend of eight occupancy bits, x exact then y and z rounded.
`default_nettype none
module vots_blend (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [7:0]  i_occ,
    input  wire logic [15:0] i_fx,
    input  wire logic [15:0] i_fy,
    input  wire logic [15:0] i_fz,
    output logic      [16:0] o_density
);
    import vots_pkg::*;

    logic [16:0] w_one;
    logic [16:0] w_f [4];
    logic [16:0] r_f [4];
    logic [15:0] r_fy;
    logic [15:0] r_fz1;
    logic [16:0] r_f0;
    logic [16:0] r_f1;
    logic [15:0] r_fz2;
    logic [34:0] w_a0;
    logic [34:0] w_a1;
    logic [34:0] w_d;

    assign w_one = 17'h10000;

    // Corner order: bit 2*k is x low, 2*k+1 is x high, k = y + 2z.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_f[k] = (i_occ[2*k] ? w_one - {1'b0, i_fx} : 17'd0)
                   + (i_occ[2*k+1] ? {1'b0, i_fx} : 17'd0);
        end
    end

    assign w_a0 = {18'd0, r_f[0]} * {18'd0, w_one - {1'b0, r_fy}}
                + {18'd0, r_f[1]} * {19'd0, r_fy} + 35'd32768;
    assign w_a1 = {18'd0, r_f[2]} * {18'd0, w_one - {1'b0, r_fy}}
                + {18'd0, r_f[3]} * {19'd0, r_fy} + 35'd32768;
    assign w_d  = {18'd0, r_f0} * {18'd0, w_one - {1'b0, r_fz2}}
                + {18'd0, r_f1} * {19'd0, r_fz2} + 35'd32768;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f       <= w_f;
            r_fy      <= i_fy;
            r_fz1     <= i_fz;
            r_f0      <= w_a0[32:16];
            r_f1      <= w_a1[32:16];
            r_fz2     <= r_fz1;
            o_density <= w_d[32:16];
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/voxel_occupancy_trilinear_sampler_top.sv
// Top level of the voxel occupancy sampler: config, pipeline, banks, output.
// A query word's result passes the axis, neighbour clamp, bank address, bank read and blend registers.
// Throughput: one word per cycle while no valid output is stalled; a write or a query may then enter every cycle.
// The whole pipeline advances together and freezes when a valid output is stalled.
// The occupancy banks are not cleared; reset clears valid bits and loads the config defaults.
`default_nettype none
module voxel_occupancy_trilinear_sampler_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_opcode,
    input  wire logic [5:0]  i_voxel_x,
    input  wire logic [5:0]  i_voxel_y,
    input  wire logic [5:0]  i_voxel_z,
    input  wire logic        i_occupied,
    input  wire logic [31:0] i_point_x,
    input  wire logic [31:0] i_point_y,
    input  wire logic [31:0] i_point_z,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [16:0]      o_density,
    output logic             o_outside,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import vots_pkg::*;

    localparam int AW = $clog2(MAX_DIM) < 1 ? 1 : $clog2(MAX_DIM);
    localparam int HW = AW > 1 ? AW - 1 : 1;
    localparam int BANK_D = (MAX_DIM + 1) / 2;
    localparam int BA = 3 * HW;
    localparam int DEPTH = 9;

    logic [31:0] r_org [3];
    logic [31:0] r_scl [3];
    logic [20:0] r_dims;
    logic [7:0]  w_dim [3];
    logic        w_en;
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] r_qry;
    t_axis       w_ax [3];
    logic [7:0]  r_dimp [3][3];
    logic [AW-1:0] r_nb [3][2];
    logic [15:0] r_fr [3];
    logic        r_out;
    logic [15:0] r_fr2 [3];
    logic        r_out2;
    logic [15:0] r_fr3 [3];
    logic        r_out3;
    logic [1:0]  r_par [3];
    logic [1:0]  r_par2 [3];
    logic [7:0]  w_occ;
    logic [7:0]  w_rd;
    logic [2:0]  r_out_d;
    logic [16:0] w_dens;
    logic [4:0]  r_wv;
    logic [18:0] r_wd [5];
    logic [BA-1:0] w_radr [8];
    logic [BA-1:0] r_radr [8];

    // The entire pipeline moves unless a valid output is stalled.
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= 32'hFFFF8000;
            r_org[1] <= 32'hFFFF8000;
            r_org[2] <= 32'hFFFF8000;
            r_scl[0] <= 32'h00010000;
            r_scl[1] <= 32'h00010000;
            r_scl[2] <= 32'h00010000;
            r_dims   <= 21'd16513;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ORIGIN_X:  r_org[0] <= i_cfg_data;
                REG_ORIGIN_Y:  r_org[1] <= i_cfg_data;
                REG_ORIGIN_Z:  r_org[2] <= i_cfg_data;
                REG_SCALE_X:   r_scl[0] <= i_cfg_data;
                REG_SCALE_Y:   r_scl[1] <= i_cfg_data;
                REG_SCALE_Z:   r_scl[2] <= i_cfg_data;
                REG_GRID_DIMS: r_dims   <= i_cfg_data[20:0];
                default: ;
            endcase
        end
    end

    // Each dimension field saturates to the range one to MAX_DIM.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r_dims[7*a +: 7] == 7'd0) begin
                w_dim[a] = 8'd1;
            end else if ({1'b0, r_dims[7*a +: 7]} > 8'(MAX_DIM)) begin
                w_dim[a] = 8'(MAX_DIM);
            end else begin
                w_dim[a] = {1'b0, r_dims[7*a +: 7]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid && i_opcode == OP_QUERY};
        end
    end
    assign r_qry = r_vld;

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_axis
            logic [31:0] w_pt;
            assign w_pt = (g == 0) ? i_point_x : (g == 1) ? i_point_y : i_point_z;
            vots_axis u_axis (
                .i_clk(i_clk), .i_en(w_en), .i_point(w_pt), .i_origin(r_org[g]),
                .i_scale(r_scl[g]), .i_dim(w_dim[g]), .o_axis(w_ax[g])
            );
        end
    endgenerate

    // Stage four: clamp the two neighbour indices on each axis.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_dimp[a][0] <= w_dim[a];
                r_dimp[a][1] <= r_dimp[a][0];
                r_dimp[a][2] <= r_dimp[a][1];
                r_fr[a] <= w_ax[a].frac;
                if (w_ax[a].neg) begin
                    r_nb[a][0] <= '0;
                end else if (w_ax[a].idx >= 17'(r_dimp[a][2]) - 17'd1) begin
                    r_nb[a][0] <= AW'(r_dimp[a][2] - 8'd1);
                end else begin
                    r_nb[a][0] <= AW'(w_ax[a].idx);
                end
                if (w_ax[a].neg) begin
                    r_nb[a][1] <= '0;
                end else if (w_ax[a].idx + 17'd1 >= 17'(r_dimp[a][2]) - 17'd1) begin
                    r_nb[a][1] <= AW'(r_dimp[a][2] - 8'd1);
                end else begin
                    r_nb[a][1] <= AW'(w_ax[a].idx + 17'd1);
                end
            end
            r_out <= w_ax[0].outside || w_ax[1].outside || w_ax[2].outside;
        end
    end

    // Each bank takes, per axis, the neighbour whose low index bit matches its
    // own parity. Clamped neighbours are equal, so either choice is right.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_radr[b] = {
                (r_nb[2][0][0] == b[2]) ? r_nb[2][0][AW-1 -: HW] : r_nb[2][1][AW-1 -: HW],
                (r_nb[1][0][0] == b[1]) ? r_nb[1][0][AW-1 -: HW] : r_nb[1][1][AW-1 -: HW],
                (r_nb[0][0][0] == b[0]) ? r_nb[0][0][AW-1 -: HW] : r_nb[0][1][AW-1 -: HW]
            };
        end
    end

    // Stage five: register the bank addresses and the neighbour parities.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int b = 0; b < 8; b++) begin
                r_radr[b] <= w_radr[b];
            end
            for (int a = 0; a < 3; a++) begin
                r_par[a] <= {r_nb[a][1][0], r_nb[a][0][0]};
                r_fr2[a] <= r_fr[a];
            end
            r_out2 <= r_out;
        end
    end

    // Write words travel down the pipeline and reach the banks at the read
    // stage, so every query sees exactly the writes accepted before it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= '0;
        end else if (w_en) begin
            r_wv <= {r_wv[3:0], i_valid && i_opcode == OP_WRITE};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wd[0] <= {i_occupied, i_voxel_z, i_voxel_y, i_voxel_x};
            for (int k = 1; k < 5; k++) begin
                r_wd[k] <= r_wd[k-1];
            end
        end
    end

    generate
        for (g = 0; g < 8; g++) begin : g_bank
            logic          r_mem [BANK_D*BANK_D*BANK_D];
            logic          r_q;
            logic [AW-1:0] w_wx;
            logic [AW-1:0] w_wy;
            logic [AW-1:0] w_wz;
            assign w_wx = AW'(r_wd[4][5:0]);
            assign w_wy = AW'(r_wd[4][11:6]);
            assign w_wz = AW'(r_wd[4][17:12]);
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    if (r_wv[4] && {w_wz[0], w_wy[0], w_wx[0]} == 3'(g)) begin
                        r_mem[{w_wz[AW-1 -: HW], w_wy[AW-1 -: HW], w_wx[AW-1 -: HW]}]
                            <= r_wd[4][18];
                    end
                    r_q <= r_mem[r_radr[g]];
                end
            end
            assign w_rd[g] = r_q;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_fr3[a] <= r_fr2[a];
                r_par2[a] <= r_par[a];
            end
            r_out3 <= r_out2;
            r_out_d <= {r_out_d[1:0], r_out3};
        end
    end

    // Pick each corner's bit from the bank matching its index parity.
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            w_occ[c] = w_rd[{r_par2[2][c[2]], r_par2[1][c[1]], r_par2[0][c[0]]}];
        end
    end

    vots_blend u_blend (
        .i_clk(i_clk), .i_en(w_en), .i_occ(w_occ),
        .i_fx(r_fr3[0]), .i_fy(r_fr3[1]), .i_fz(r_fr3[2]), .o_density(w_dens)
    );

    assign o_valid   = r_qry[DEPTH-1];
    assign o_outside = r_out_d[2];
    assign o_density = r_out_d[2] ? 17'd0 : w_dens;

    property p_stall_holds;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid && i_stall |=> o_valid;
    endproperty
    a_stall_holds: assert property (p_stall_holds) else $error("result lost");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_density <= 17'h10000) else $error("density above one");

    a_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outside |-> o_density == 17'd0) else $error("outside nonzero");
endmodule
`default_nettype wire
